>>> rtl/crsh_pkg.sv
// Shared types, codes and helpers for the closest ray segment hit block.
package crsh_pkg;

	// Request codes as they arrive on the input channel.
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	// Configuration register indexes (byte address bit 2).
	localparam logic REG_SCENE_WIDTH  = 1'b0;
	localparam logic REG_SCENE_HEIGHT = 1'b1;

	// Scene size registers and their reset values.
	localparam int CFG_W = 13;
	localparam logic [CFG_W-1:0] SCENE_WIDTH_RST  = 13'd1280;
	localparam logic [CFG_W-1:0] SCENE_HEIGHT_RST = 13'd720;

	// Far point coordinate width: (2*size+1) in Q.4.
	localparam int FAR_W = CFG_W + 5;

	// Commands passed from the front queue to the engine.
	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_CLEAR,
		CMD_QUERY
	} crsh_cmd_t;

	// Engine sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_CMP,
		ST_WALK,
		ST_DIV
	} crsh_state_t;

	// Far coordinate (2*size+1)*16 built by concatenation.
	function automatic logic [FAR_W-1:0] far_coord(input logic [CFG_W-1:0] size);
		return {size, 1'b1, 4'b0000};
	endfunction

endpackage

>>> rtl/crsh_if.sv
// Request and result channel interfaces.
interface crsh_req_if #(
	parameter int COORD_BITS = 20
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic signed [COORD_BITS-1:0] point_a_x;
	logic signed [COORD_BITS-1:0] point_a_y;
	logic signed [COORD_BITS-1:0] point_b_x;
	logic signed [COORD_BITS-1:0] point_b_y;
	logic                         closes_polygon;

	modport source (output valid, req_type, point_a_x, point_a_y, point_b_x, point_b_y,
		closes_polygon, input ready);
	modport sink (input valid, req_type, point_a_x, point_a_y, point_b_x, point_b_y,
		closes_polygon, output ready);
endinterface

interface crsh_res_if #(
	parameter int COORD_BITS = 20
);
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic signed [COORD_BITS-1:0] hit_x;
	logic signed [COORD_BITS-1:0] hit_y;
	logic                         table_full;

	modport source (output valid, found, hit_x, hit_y, table_full, input ready);
	modport sink (input valid, found, hit_x, hit_y, table_full, output ready);
endinterface

>>> rtl/crsh_front.sv
// Front end: accepts requests, classifies them and queues commands for the engine.
module crsh_front #(
	parameter int COORD_BITS = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   in_req_type,
	input  logic signed [COORD_BITS-1:0] in_ax,
	input  logic signed [COORD_BITS-1:0] in_ay,
	input  logic signed [COORD_BITS-1:0] in_bx,
	input  logic signed [COORD_BITS-1:0] in_by,
	input  logic                         in_closes,
	output logic                         cmd_valid,
	input  logic                         cmd_ready,
	output crsh_pkg::crsh_cmd_t          cmd_kind,
	output logic signed [COORD_BITS-1:0] cmd_ax,
	output logic signed [COORD_BITS-1:0] cmd_ay,
	output logic signed [COORD_BITS-1:0] cmd_bx,
	output logic signed [COORD_BITS-1:0] cmd_by,
	output logic                         cmd_closes
);

	typedef struct packed {
		crsh_pkg::crsh_cmd_t          kind;
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
		logic                         closes;
	} entry_t;

	entry_t              slot_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          cnt_q;
	logic                known;
	logic                push;
	logic                pop;
	crsh_pkg::crsh_cmd_t kind;

	// Classify the request; the unused code is dropped at the transfer.
	always_comb begin
		known = 1'b1;
		kind = crsh_pkg::CMD_LOAD;
		case (in_req_type)
			crsh_pkg::REQ_LOAD:  kind = crsh_pkg::CMD_LOAD;
			crsh_pkg::REQ_CLEAR: kind = crsh_pkg::CMD_CLEAR;
			crsh_pkg::REQ_QUERY: kind = crsh_pkg::CMD_QUERY;
			default:             known = 1'b0;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready && known;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop = cmd_valid && cmd_ready;

	// Two-entry queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{kind: kind, ax: in_ax, ay: in_ay, bx: in_bx, by: in_by,
				closes: in_closes};
		end
	end

	assign cmd_kind = slot_q[rd_ptr_q].kind;
	assign cmd_ax = slot_q[rd_ptr_q].ax;
	assign cmd_ay = slot_q[rd_ptr_q].ay;
	assign cmd_bx = slot_q[rd_ptr_q].bx;
	assign cmd_by = slot_q[rd_ptr_q].by;
	assign cmd_closes = slot_q[rd_ptr_q].closes;

endmodule

>>> rtl/crsh_muldiv.sv
// Two-lane serial unit computing round(num*r/den) for both ray axes.
module crsh_muldiv #(
	parameter int COORD_BITS = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [2*COORD_BITS+2:0]      num,
	input  logic [2*COORD_BITS+2:0]      den,
	input  logic signed [COORD_BITS:0]   rx,
	input  logic signed [COORD_BITS:0]   ry,
	output logic                         done,
	output logic signed [COORD_BITS:0]   step_x,
	output logic signed [COORD_BITS:0]   step_y
);

	localparam int C = COORD_BITS;
	localparam int WW = 2 * C + 3;
	localparam int TW = WW + 2;
	localparam int CNW = $clog2(C + 1);

	logic           busy_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [WW-1:0]  num_q;
	logic [WW-1:0]  den_q;
	logic [C-1:0]   mag_q [2];
	logic           neg_q [2];
	logic [WW-1:0]  rem_q [2];
	logic [C:0]     quo_q [2];
	logic [WW-1:0]  rem_d [2];
	logic [C:0]     quo_d [2];
	logic [C:0]     r_in [2];
	logic [TW-1:0]  t;
	logic [TW-1:0]  d1;
	logic [TW-1:0]  d2;
	logic [TW-1:0]  r2;

	assign r_in[0] = rx;
	assign r_in[1] = ry;

	// One multiplier bit per cycle: remainder doubles, adds num, and sheds up to 2*den.
	always_comb begin
		t = '0;
		r2 = '0;
		d1 = TW'(den_q);
		d2 = d1 << 1;
		for (int i = 0; i < 2; i++) begin
			rem_d[i] = rem_q[i];
			quo_d[i] = quo_q[i];
			if (cnt_q != '0) begin
				t = (TW'(rem_q[i]) << 1) + (mag_q[i][C-1] ? TW'(num_q) : '0);
				if (t >= d2) begin
					rem_d[i] = WW'(t - d2);
					quo_d[i] = (quo_q[i] << 1) + (C+1)'(2);
				end else if (t >= d1) begin
					rem_d[i] = WW'(t - d1);
					quo_d[i] = (quo_q[i] << 1) + (C+1)'(1);
				end else begin
					rem_d[i] = WW'(t);
					quo_d[i] = quo_q[i] << 1;
				end
			end else begin
				r2 = TW'(rem_q[i]) << 1;
				if (r2 >= d1) quo_d[i] = quo_q[i] + (C+1)'(1);
			end
		end
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNW'(C);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNW'(1);
				end
			end
		end
	end

	// Lane datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			for (int i = 0; i < 2; i++) begin
				neg_q[i] <= r_in[i][C];
				mag_q[i] <= r_in[i][C] ? C'(-r_in[i]) : C'(r_in[i]);
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= rem_d[i];
				quo_q[i] <= quo_d[i];
				mag_q[i] <= mag_q[i] << 1;
			end
		end
	end

	assign done = done_q;
	assign step_x = neg_q[0] ? -$signed(quo_q[0]) : $signed(quo_q[0]);
	assign step_y = neg_q[1] ? -$signed(quo_q[1]) : $signed(quo_q[1]);

endmodule

>>> rtl/crsh_back.sv
// Engine: vertex table, pipelined edge walk, hit point and nearest-hit tracking.
module crsh_back #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  crsh_pkg::crsh_cmd_t            cmd_kind,
	input  logic signed [COORD_BITS-1:0]   cmd_ax,
	input  logic signed [COORD_BITS-1:0]   cmd_ay,
	input  logic signed [COORD_BITS-1:0]   cmd_bx,
	input  logic signed [COORD_BITS-1:0]   cmd_by,
	input  logic                           cmd_closes,
	input  logic [crsh_pkg::FAR_W-1:0]     far_x,
	input  logic [crsh_pkg::FAR_W-1:0]     far_y,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic                           res_found,
	output logic signed [COORD_BITS-1:0]   res_hit_x,
	output logic signed [COORD_BITS-1:0]   res_hit_y,
	output logic                           res_table_full
);

	localparam int C = COORD_BITS;
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int EW = 2 * C + AW;
	localparam int PW = 2 * C + 2;
	localparam int WW = 2 * C + 3;
	localparam int BW = (C > crsh_pkg::FAR_W) ? C : crsh_pkg::FAR_W + 1;
	localparam int DW = BW + 1;
	localparam int SW = 2 * DW + 1;

	crsh_pkg::crsh_state_t state_q, state_d;

	// Vertex table: {x, y, next index}.
	logic [EW-1:0] mem [MAX_VERTICES];

	logic [CW-1:0] vcount_q, closed_q, pstart_q, next_idx;
	logic [CW-1:0] k_q;
	logic          res_valid_q, init_q, got_q;
	logic          take, is_full, issue, keep, flush_hit, walk_done, pipe_busy;

	logic signed [C-1:0]  ax_q, ay_q;
	logic signed [C:0]    rdx_q, rdy_q;
	logic signed [DW-1:0] sqa_q, sqb_q;
	logic signed [2*DW-1:0] sq1_q, sq2_q;
	logic [SW-1:0]        bestd_q, dsum;
	logic signed [BW-1:0] best_x_q, best_y_q, cand_x_q, cand_y_q;

	// Walk pipeline.
	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic [EW-1:0] pa_s1, pb_s2;
	logic signed [C-1:0]  e0x_s2, e0y_s2;
	logic signed [C:0]    sdx_s3, sdy_s3, odx_s3, ody_s3;
	logic signed [PW-1:0] prs_s4, psr_s4, pos_s4, pso_s4, por_s4, pro_s4;
	logic signed [WW-1:0] den_s5, tn_s5, un_s5;
	logic          hit_s6;
	logic [WW-1:0] tabs_s6, dabs_s6;
	logic          dneg, tok, uok, hit;

	logic                div_done;
	logic signed [C:0]   step_x, step_y;

	assign cmd_ready = (state_q == crsh_pkg::ST_IDLE) && !res_valid_q;
	assign take = cmd_valid && cmd_ready;
	assign is_full = (vcount_q == CW'(MAX_VERTICES));
	assign next_idx = vcount_q + CW'(1);
	assign flush_hit = v_s6 && hit_s6;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6;
	assign issue = (state_q == crsh_pkg::ST_WALK) && !flush_hit && (k_q < closed_q);
	assign keep = (state_q == crsh_pkg::ST_WALK) && !flush_hit;
	assign walk_done = (state_q == crsh_pkg::ST_WALK) && (k_q == closed_q) && !pipe_busy;
	assign dsum = SW'($unsigned(sq1_q)) + SW'($unsigned(sq2_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			crsh_pkg::ST_IDLE: if (take && cmd_kind == crsh_pkg::CMD_QUERY) begin
				state_d = crsh_pkg::ST_SQ;
			end
			crsh_pkg::ST_SQ: state_d = crsh_pkg::ST_CMP;
			crsh_pkg::ST_CMP: state_d = crsh_pkg::ST_WALK;
			crsh_pkg::ST_WALK: begin
				if (flush_hit) state_d = crsh_pkg::ST_DIV;
				else if (walk_done) state_d = crsh_pkg::ST_IDLE;
			end
			crsh_pkg::ST_DIV: if (div_done) state_d = crsh_pkg::ST_SQ;
			default: state_d = crsh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= crsh_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Control registers: table counts, walk index, pipeline valids, result slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			closed_q <= '0;
			pstart_q <= '0;
			k_q <= '0;
			res_valid_q <= 1'b0;
			init_q <= 1'b0;
			got_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			if (take) begin
				case (cmd_kind)
					crsh_pkg::CMD_LOAD: begin
						res_valid_q <= 1'b1;
						if (!is_full) begin
							vcount_q <= next_idx;
							if (cmd_closes) begin
								pstart_q <= next_idx;
								closed_q <= next_idx;
							end
						end
					end
					crsh_pkg::CMD_CLEAR: begin
						vcount_q <= '0;
						closed_q <= '0;
						pstart_q <= '0;
					end
					crsh_pkg::CMD_QUERY: begin
						k_q <= '0;
						init_q <= 1'b1;
						got_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == crsh_pkg::ST_CMP) begin
				init_q <= 1'b0;
				if (!init_q && dsum < bestd_q) got_q <= 1'b1;
			end
			if (issue) k_q <= k_q + CW'(1);
			else if (flush_hit) k_q <= CW'(idx_s6) + CW'(1);
			if (walk_done) res_valid_q <= 1'b1;
			v_s1 <= issue;
			v_s2 <= v_s1 && keep;
			v_s3 <= v_s2 && keep;
			v_s4 <= v_s3 && keep;
			v_s5 <= v_s4 && keep;
			v_s6 <= v_s5 && keep;
		end
	end

	// Table writes.
	always_ff @(posedge clk) begin
		if (take && cmd_kind == crsh_pkg::CMD_LOAD && !is_full) begin
			mem[vcount_q[AW-1:0]] <= {cmd_ax, cmd_ay,
				cmd_closes ? pstart_q[AW-1:0] : next_idx[AW-1:0]};
		end
	end

	// Walk pipeline: read edge start, read edge end, differences, products,
	// cross terms, then the inclusive parameter test.
	always_comb begin
		dneg = den_s5[WW-1];
		if (dneg) begin
			tok = (tn_s5[WW-1] || tn_s5 == '0) && (tn_s5 >= den_s5);
			uok = (un_s5[WW-1] || un_s5 == '0) && (un_s5 >= den_s5);
		end else begin
			tok = !tn_s5[WW-1] && (tn_s5 <= den_s5);
			uok = !un_s5[WW-1] && (un_s5 <= den_s5);
		end
		hit = (den_s5 != '0) && tok && uok;
	end

	always_ff @(posedge clk) begin
		pa_s1 <= mem[k_q[AW-1:0]];
		idx_s1 <= k_q[AW-1:0];
		pb_s2 <= mem[pa_s1[AW-1:0]];
		e0x_s2 <= pa_s1[EW-1 -: C];
		e0y_s2 <= pa_s1[AW +: C];
		idx_s2 <= idx_s1;
		sdx_s3 <= (C+1)'($signed(pb_s2[EW-1 -: C])) - (C+1)'(e0x_s2);
		sdy_s3 <= (C+1)'($signed(pb_s2[AW +: C])) - (C+1)'(e0y_s2);
		odx_s3 <= (C+1)'(e0x_s2) - (C+1)'(ax_q);
		ody_s3 <= (C+1)'(e0y_s2) - (C+1)'(ay_q);
		idx_s3 <= idx_s2;
		prs_s4 <= rdx_q * sdy_s3;
		psr_s4 <= rdy_q * sdx_s3;
		pos_s4 <= odx_s3 * sdy_s3;
		pso_s4 <= ody_s3 * sdx_s3;
		por_s4 <= odx_s3 * rdy_q;
		pro_s4 <= ody_s3 * rdx_q;
		idx_s4 <= idx_s3;
		den_s5 <= WW'(prs_s4) - WW'(psr_s4);
		tn_s5 <= WW'(pos_s4) - WW'(pso_s4);
		un_s5 <= WW'(por_s4) - WW'(pro_s4);
		idx_s5 <= idx_s4;
		hit_s6 <= hit;
		tabs_s6 <= dneg ? WW'(-tn_s5) : WW'(tn_s5);
		dabs_s6 <= dneg ? WW'(-den_s5) : WW'(den_s5);
		idx_s6 <= idx_s5;
	end

	// Query datapath: far point setup, candidate squares, nearest-hit update, result.
	always_ff @(posedge clk) begin
		if (take && cmd_kind == crsh_pkg::CMD_QUERY) begin
			ax_q <= cmd_ax;
			ay_q <= cmd_ay;
			rdx_q <= (C+1)'(cmd_bx) - (C+1)'(cmd_ax);
			rdy_q <= (C+1)'(cmd_by) - (C+1)'(cmd_ay);
			sqa_q <= $signed({{(DW-crsh_pkg::FAR_W){1'b0}}, far_x}) - DW'(cmd_ax);
			sqb_q <= $signed({{(DW-crsh_pkg::FAR_W){1'b0}}, far_y}) - DW'(cmd_ay);
			best_x_q <= $signed({{(BW-crsh_pkg::FAR_W){1'b0}}, far_x});
			best_y_q <= $signed({{(BW-crsh_pkg::FAR_W){1'b0}}, far_y});
		end
		if (state_q == crsh_pkg::ST_DIV && div_done) begin
			sqa_q <= DW'(step_x);
			sqb_q <= DW'(step_y);
			cand_x_q <= BW'(ax_q) + BW'(step_x);
			cand_y_q <= BW'(ay_q) + BW'(step_y);
		end
		if (state_q == crsh_pkg::ST_SQ) begin
			sq1_q <= sqa_q * sqa_q;
			sq2_q <= sqb_q * sqb_q;
		end
		if (state_q == crsh_pkg::ST_CMP) begin
			if (init_q) begin
				bestd_q <= dsum;
			end else if (dsum < bestd_q) begin
				bestd_q <= dsum;
				best_x_q <= cand_x_q;
				best_y_q <= cand_y_q;
			end
		end
		if (take && cmd_kind == crsh_pkg::CMD_LOAD) begin
			res_found <= 1'b0;
			res_hit_x <= '0;
			res_hit_y <= '0;
			res_table_full <= is_full;
		end else if (walk_done) begin
			res_found <= got_q;
			res_hit_x <= best_x_q[C-1:0];
			res_hit_y <= best_y_q[C-1:0];
			res_table_full <= 1'b0;
		end
	end

	crsh_muldiv #(
		.COORD_BITS(COORD_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (flush_hit && state_q == crsh_pkg::ST_WALK),
		.num    (tabs_s6),
		.den    (dabs_s6),
		.rx     (rdx_q),
		.ry     (rdy_q),
		.done   (div_done),
		.step_x (step_x),
		.step_y (step_y)
	);

	assign res_valid = res_valid_q;

endmodule

>>> rtl/closest_ray_segment_hit.sv
// Top level: configuration registers, request front end and hit engine.
//
//  Channel  Direction  Transfer contents
//  req      in         req_type, point_a_x/y, point_b_x/y, closes_polygon
//  res      out        found, hit_x, hit_y, table_full (none for a clear)
//  APB      in/out     scene_width at 0x0, scene_height at 0x4
//
// In a query the edge walk is a six-stage pipeline taking one edge per cycle over
// the closed edges, and each edge that crosses the ray restarts it after the shared
// serial multiply-divide unit, which takes one bit per cycle.
// Reset empties the table and loads the default scene size. A stalled result
// waits in the output register while the two-entry front queue keeps accepting
// until it is full.
module closest_ray_segment_hit #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	crsh_req_if.sink    req,
	crsh_res_if.source  res
);

	logic [crsh_pkg::CFG_W-1:0] width_q, height_q;

	logic                         cmd_valid, cmd_ready, cmd_closes;
	crsh_pkg::crsh_cmd_t          cmd_kind;
	logic signed [COORD_BITS-1:0] cmd_ax, cmd_ay, cmd_bx, cmd_by;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= crsh_pkg::SCENE_WIDTH_RST;
			height_q <= crsh_pkg::SCENE_HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				crsh_pkg::REG_SCENE_WIDTH:  width_q <= pwdata[crsh_pkg::CFG_W-1:0];
				crsh_pkg::REG_SCENE_HEIGHT: height_q <= pwdata[crsh_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[2])
			crsh_pkg::REG_SCENE_WIDTH:  prdata = 32'(width_q);
			crsh_pkg::REG_SCENE_HEIGHT: prdata = 32'(height_q);
			default:                    prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	crsh_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.in_req_type (req.req_type),
		.in_ax       (req.point_a_x),
		.in_ay       (req.point_a_y),
		.in_bx       (req.point_b_x),
		.in_by       (req.point_b_y),
		.in_closes   (req.closes_polygon),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd_kind    (cmd_kind),
		.cmd_ax      (cmd_ax),
		.cmd_ay      (cmd_ay),
		.cmd_bx      (cmd_bx),
		.cmd_by      (cmd_by),
		.cmd_closes  (cmd_closes)
	);

	crsh_back #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd_kind       (cmd_kind),
		.cmd_ax         (cmd_ax),
		.cmd_ay         (cmd_ay),
		.cmd_bx         (cmd_bx),
		.cmd_by         (cmd_by),
		.cmd_closes     (cmd_closes),
		.far_x          (crsh_pkg::far_coord(width_q)),
		.far_y          (crsh_pkg::far_coord(height_q)),
		.res_valid      (res.valid),
		.res_ready      (res.ready),
		.res_found      (res.found),
		.res_hit_x      (res.hit_x),
		.res_hit_y      (res.hit_y),
		.res_table_full (res.table_full)
	);

endmodule

>>> bench/closest_ray_segment_hit_tb.sv
// Self-checking testbench for the closest ray segment hit block.
module closest_ray_segment_hit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 20;
	localparam int MAXV = 64;
	localparam int STALL_LIMIT = 20000;

	// Request code that the block ignores.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef logic signed [127:0] wide_t;
	typedef logic signed [CB-1:0] coord_t;

	typedef struct {
		logic [1:0] kind;
		coord_t     ax;
		coord_t     ay;
		coord_t     bx;
		coord_t     by;
		logic       closes;
	} request_t;

	typedef struct {
		logic   found;
		coord_t hx;
		coord_t hy;
		logic   full;
	} hit_t;

	// Vertex table model and queue of expected hit results.
	class hit_scoreboard;
		coord_t      vx [MAXV];
		coord_t      vy [MAXV];
		int          link [MAXV];
		int          vcount;
		int          ccount;
		int          pstart;
		int unsigned width_px;
		int unsigned height_px;
		hit_t        pending [$];
		int          errors;

		function new();
			vcount = 0;
			ccount = 0;
			pstart = 0;
			width_px = crsh_pkg::SCENE_WIDTH_RST;
			height_px = crsh_pkg::SCENE_HEIGHT_RST;
			errors = 0;
		endfunction

		function wide_t cross_prod(wide_t px, wide_t py, wide_t qx, wide_t qy);
			return px * qy - py * qx;
		endfunction

		// Rounded step tn*d/den, halves away from zero.
		function wide_t scaled(wide_t tn, wide_t d, wide_t den);
			wide_t p;
			wide_t m;
			wide_t q;
			wide_t r;
			p = tn * d;
			m = (p < 0) ? -p : p;
			q = m / den;
			r = m % den;
			if (2 * r >= den) begin
				q = q + 1;
			end
			return (p < 0) ? -q : q;
		endfunction

		// Nearest crossing of the ray with every closed edge.
		function hit_t run_query(request_t r);
			hit_t  h;
			wide_t ax, ay, bx, by, ex0, ey0, ex1, ey1;
			wide_t rdx, rdy, sdx, sdy, odx, ody, den, tn, un;
			wide_t px, py, bestx, besty, bestd, dd;
			int    nx;
			ax = r.ax;
			ay = r.ay;
			bx = r.bx;
			by = r.by;
			bestx = (2 * width_px + 1) * 16;
			besty = (2 * height_px + 1) * 16;
			bestd = (bestx - ax) * (bestx - ax) + (besty - ay) * (besty - ay);
			h.found = 1'b0;
			for (int k = 0; k < ccount; k++) begin
				nx = link[k];
				ex0 = vx[k];
				ey0 = vy[k];
				ex1 = vx[nx];
				ey1 = vy[nx];
				rdx = bx - ax;
				rdy = by - ay;
				sdx = ex1 - ex0;
				sdy = ey1 - ey0;
				odx = ex0 - ax;
				ody = ey0 - ay;
				den = cross_prod(rdx, rdy, sdx, sdy);
				if (den == 0) begin
					continue;
				end
				tn = cross_prod(odx, ody, sdx, sdy);
				un = cross_prod(odx, ody, rdx, rdy);
				if (den < 0) begin
					den = -den;
					tn = -tn;
					un = -un;
				end
				if (tn < 0 || tn > den || un < 0 || un > den) begin
					continue;
				end
				px = ax + scaled(tn, rdx, den);
				py = ay + scaled(tn, rdy, den);
				dd = (px - ax) * (px - ax) + (py - ay) * (py - ay);
				if (dd < bestd) begin
					bestd = dd;
					bestx = px;
					besty = py;
					h.found = 1'b1;
				end
			end
			h.hx = bestx[CB-1:0];
			h.hy = besty[CB-1:0];
			h.full = 1'b0;
			return h;
		endfunction

		// Update the table for an accepted request and queue its result, if it has one.
		function void note_request(request_t r);
			hit_t h;
			case (r.kind)
				crsh_pkg::REQ_LOAD: begin
					h = '{1'b0, '0, '0, 1'b0};
					if (vcount >= MAXV) begin
						h.full = 1'b1;
					end else begin
						vx[vcount] = r.ax;
						vy[vcount] = r.ay;
						if (r.closes) begin
							link[vcount] = pstart;
							pstart = vcount + 1;
							ccount = vcount + 1;
						end else begin
							link[vcount] = vcount + 1;
						end
						vcount++;
					end
					pending.push_back(h);
				end
				crsh_pkg::REQ_CLEAR: begin
					vcount = 0;
					ccount = 0;
					pstart = 0;
				end
				crsh_pkg::REQ_QUERY: begin
					pending.push_back(run_query(r));
				end
				default: begin
				end
			endcase
		endfunction

		// Compare one result transfer with the oldest expectation.
		function void check_result(hit_t a);
			hit_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result found=%0b x=%0d y=%0d full=%0b",
					$realtime, a.found, a.hx, a.hy, a.full);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.found !== e.found) begin
				$display("%0t: found expected %0b actual %0b", $realtime, e.found, a.found);
				errors++;
			end
			if (a.hx !== e.hx) begin
				$display("%0t: hit_x expected %0d actual %0d", $realtime, e.hx, a.hx);
				errors++;
			end
			if (a.hy !== e.hy) begin
				$display("%0t: hit_y expected %0d actual %0d", $realtime, e.hy, a.hy);
				errors++;
			end
			if (a.full !== e.full) begin
				$display("%0t: table_full expected %0b actual %0b", $realtime, e.full, a.full);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        quiet;
	int          stall_cycles;

	crsh_req_if #(.COORD_BITS(CB)) req ();
	crsh_res_if #(.COORD_BITS(CB)) res ();

	hit_scoreboard sb;

	closest_ray_segment_hit #(.MAX_VERTICES(MAXV), .COORD_BITS(CB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req),
		.res(res)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result sink readiness in random stall bursts.
	initial begin
		forever begin
			res.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!quiet && $urandom_range(0, 1) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	// Check every result transfer.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			sb.check_result('{res.found, res.hit_x, res.hit_y, res.table_full});
		end
	end

	// Stop the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready) || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Send one request, at random and only when not quiet with a gap ahead of it.
	task automatic send_req(input request_t r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= r.kind;
		req.point_a_x <= r.ax;
		req.point_a_y <= r.ay;
		req.point_b_x <= r.bx;
		req.point_b_y <= r.by;
		req.closes_polygon <= r.closes;
		do @(posedge clk); while (!req.ready);
		sb.note_request(r);
	endtask

	task automatic send(input logic [1:0] kind, input int ax, input int ay,
		input int bx, input int by, input logic closes);
		request_t r;
		r = '{kind, ax[CB-1:0], ay[CB-1:0], bx[CB-1:0], by[CB-1:0], closes};
		send_req(r);
	endtask

	// Wait until every result is back and the engine has settled.
	task automatic drain();
		req.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == crsh_pkg::REG_SCENE_WIDTH) begin
			sb.width_px = value;
		end else begin
			sb.height_px = value;
		end
	endtask

	function automatic int coord_rand(input int span);
		if ($urandom_range(0, 9) == 0) begin
			return $signed($urandom_range(0, (1 << CB) - 1) << (32 - CB)) >>> (32 - CB);
		end
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// One random phase: mostly random rays, polygons and some noise.
	task automatic random_phase(input int count);
		int n;
		int nv;
		int cx;
		int cy;
		int rad;
		n = 0;
		while (n < count) begin
			case ($urandom_range(0, 19))
				0: begin
					send(crsh_pkg::REQ_CLEAR, coord_rand(4000), coord_rand(4000),
						coord_rand(4000), coord_rand(4000), $urandom_range(0, 1));
					n++;
				end
				1: begin
					// Unused request code: ignored by the block.
					send(REQ_UNUSED, coord_rand(4000), coord_rand(4000), coord_rand(4000),
						coord_rand(4000), $urandom_range(0, 1));
				end
				2, 3, 4, 5, 6, 7: begin
					nv = $urandom_range(1, 8);
					cx = coord_rand(3000);
					cy = coord_rand(3000);
					rad = $urandom_range(16, 2000);
					for (int i = 0; i < nv; i++) begin
						send(crsh_pkg::REQ_LOAD, cx + $urandom_range(0, 2 * rad) - rad,
							cy + $urandom_range(0, 2 * rad) - rad, coord_rand(4000),
							coord_rand(4000), (i == nv - 1) || ($urandom_range(0, 15) == 0));
						n++;
					end
				end
				8: begin
					// Broken polygon: vertices left open.
					send(crsh_pkg::REQ_LOAD, coord_rand(4000), coord_rand(4000),
						coord_rand(4000), coord_rand(4000), 1'b0);
					n++;
				end
				default: begin
					send(crsh_pkg::REQ_QUERY, coord_rand(5000), coord_rand(5000),
						coord_rand(5000), coord_rand(5000), $urandom_range(0, 1));
					n++;
				end
			endcase
		end
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		stall_cycles = 0;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req.valid <= 1'b0;
		req.req_type <= crsh_pkg::REQ_CLEAR;
		req.point_a_x <= '0;
		req.point_a_y <= '0;
		req.point_b_x <= '0;
		req.point_b_y <= '0;
		req.closes_polygon <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, degenerate edge, triangle, edge cases, extremes.
		send(crsh_pkg::REQ_QUERY, 0, 0, 320, 320, 1'b0);
		send(crsh_pkg::REQ_LOAD, 100, 100, 0, 0, 1'b1);
		send(crsh_pkg::REQ_QUERY, 0, 0, 320, 320, 1'b0);
		send(crsh_pkg::REQ_CLEAR, 0, 0, 0, 0, 1'b0);
		send(crsh_pkg::REQ_LOAD, 0, 0, 0, 0, 1'b0);
		send(crsh_pkg::REQ_LOAD, 320, 0, 0, 0, 1'b0);
		send(crsh_pkg::REQ_LOAD, 0, 320, 0, 0, 1'b1);
		send(crsh_pkg::REQ_QUERY, -160, 160, 480, 160, 1'b0);
		send(crsh_pkg::REQ_QUERY, -160, -16, 480, -16, 1'b0);
		send(crsh_pkg::REQ_QUERY, -160, 0, 480, 0, 1'b0);
		send(crsh_pkg::REQ_QUERY, -160, -160, 160, 160, 1'b0);
		send(crsh_pkg::REQ_QUERY, 0, 160, -160, 160, 1'b0);
		send(crsh_pkg::REQ_QUERY, 100, 100, 101, 101, 1'b0);
		// Open polygon after the closed one.
		send(crsh_pkg::REQ_LOAD, -1000, -1000, 0, 0, 1'b0);
		send(crsh_pkg::REQ_LOAD, 1000, -1000, 0, 0, 1'b0);
		send(crsh_pkg::REQ_QUERY, 0, -2000, 0, 2000, 1'b0);
		send(REQ_UNUSED, -1, -1, -1, -1, 1'b1);
		send(crsh_pkg::REQ_LOAD, -524288, 524287, 0, 0, 1'b0);
		send(crsh_pkg::REQ_LOAD, 524287, -524288, 0, 0, 1'b1);
		send(crsh_pkg::REQ_QUERY, -524288, -524288, 524287, 524287, 1'b1);
		send(crsh_pkg::REQ_QUERY, 524287, 524287, -524288, -524288, 1'b0);
		send(crsh_pkg::REQ_CLEAR, -1, -1, -1, -1, 1'b1);
		// Fill the table past its end.
		for (int i = 0; i < MAXV + 2; i++) begin
			send(crsh_pkg::REQ_LOAD, (i % 8) * 64, (i / 8) * 64, 0, 0, (i % 4) == 3);
		end
		send(crsh_pkg::REQ_QUERY, -10, -10, 600, 600, 1'b0);
		drain();

		// Random phases over several scene sizes.
		reg_write(crsh_pkg::REG_SCENE_WIDTH, 1);
		reg_write(crsh_pkg::REG_SCENE_HEIGHT, 1);
		random_phase(400);
		drain();
		reg_write(crsh_pkg::REG_SCENE_WIDTH, 4096);
		reg_write(crsh_pkg::REG_SCENE_HEIGHT, 4096);
		random_phase(400);
		drain();
		reg_write(crsh_pkg::REG_SCENE_WIDTH, $urandom_range(1, 4096));
		reg_write(crsh_pkg::REG_SCENE_HEIGHT, $urandom_range(1, 4096));
		random_phase(400);
		drain();
		reg_write(crsh_pkg::REG_SCENE_WIDTH, 1280);
		reg_write(crsh_pkg::REG_SCENE_HEIGHT, 720);
		random_phase(200);
		quiet = 1'b1;
		random_phase(200);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
